### rtl/core/line_pixel_stepper_defines.svh
// assertion macros for the line pixel stepper
// no dependencies; taken in by the files that carry concurrent checks
`ifndef LINE_PIXEL_STEPPER_DEFINES_SVH
`define LINE_PIXEL_STEPPER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define LPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line_pixel_stepper check failed");

// next-cycle implication, checked on every rising edge out of reset
`define LPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line_pixel_stepper check failed");

`else

`define LPS_ASSERT_NOW(label, ante, cons)
`define LPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/lps_pkg.sv
// shared codes and types for the line pixel stepper
// no dependencies; used by lps_step_unit and line_pixel_stepper
package lps_pkg;

   // request kinds carried on req_tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // status of one walk step, from the step unit to the top level
   typedef struct packed {
      logic at_end;   // the position after this step is the end point
   } lps_step_flags_type;

endpackage

### rtl/core/lps_step_unit.sv
// one step of the 4-connected walk: axis choice, next position and error term
// depends on lps_pkg for the step status struct
module lps_step_unit
   import lps_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]        cur_x,
   input  logic [COORD_BITS-1:0]        cur_y,
   input  logic [COORD_BITS-1:0]        target_x,
   input  logic [COORD_BITS-1:0]        target_y,
   input  logic [COORD_BITS-1:0]        delta_x,
   input  logic [COORD_BITS-1:0]        delta_y,
   input  logic signed [COORD_BITS+1:0] error_term,
   input  logic                         step_neg_x,
   input  logic                         step_neg_y,
   output logic [COORD_BITS-1:0]        next_x,
   output logic [COORD_BITS-1:0]        next_y,
   output logic signed [COORD_BITS+1:0] next_error,
   output lps_step_flags_type           flags
);

   localparam int EXT_BITS = COORD_BITS + 3;

   logic signed [EXT_BITS-1:0] err_ext;
   logic signed [EXT_BITS-1:0] err_twice;
   logic signed [EXT_BITS-1:0] dx_ext;
   logic signed [EXT_BITS-1:0] dy_ext;
   logic signed [EXT_BITS-1:0] err_sum;
   logic                       move_x;

   // widen everything so that 2*err and -dy compare without overflow
   assign err_ext   = EXT_BITS'(error_term);
   assign err_twice = err_ext <<< 1;
   assign dx_ext    = $signed({3'b000, delta_x});
   assign dy_ext    = $signed({3'b000, delta_y});

   // x moves when 2*err > -dy
   assign move_x = err_twice > -dy_ext;

   // error term update, bounded well inside the stored width
   assign err_sum    = move_x ? (err_ext - dy_ext) : (err_ext + dx_ext);
   assign next_error = err_sum[COORD_BITS+1:0];

   // move exactly one axis by one, wrapping
   always_comb begin
      next_x = cur_x;
      next_y = cur_y;
      if (move_x) begin
         next_x = step_neg_x ? (cur_x - COORD_BITS'(1)) : (cur_x + COORD_BITS'(1));
      end else begin
         next_y = step_neg_y ? (cur_y - COORD_BITS'(1)) : (cur_y + COORD_BITS'(1));
      end
   end

   // status for the top level
   assign flags.at_end = (next_x == target_x) && (next_y == target_y);

endmodule

### rtl/core/line_pixel_stepper.sv
// line pixel stepper top level: request handling, walk state and result register
// depends on lps_pkg, lps_step_unit and line_pixel_stepper_defines.svh
//
// Integer line rasteriser of the 4-connected Bresenham kind. A load item
// (req_tuser = 0) sets up a line from its start to its end point and gives
// no result; a load whose start equals its end leaves the block idle. Each
// step item (req_tuser = 1) while a line is active gives the current pixel
// on rsp and then moves one axis by one; rsp_tlast marks the final pixel,
// and the end point itself is never given. A step while idle gives nothing.
// Each item is handled directly: the axis choice and position update are one
// short pass of logic from the walk registers to the result register, so a
// new item is taken in every cycle while rsp is drained. All pixels share
// the fixed colour 0x00858B8C, so colour is not an output.
`include "line_pixel_stepper_defines.svh"

module line_pixel_stepper
   import lps_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata fields from bit 0: x_start, y_start, x_end, y_end, zero fill
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]   req_tdata,
   // tuser fields from bit 0: req_type
   input  logic                                req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata fields from bit 0: pixel_x, pixel_y, zero fill
   output logic [((2*COORD_BITS+7)/8)*8-1:0]   rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int RSP_DATA_BITS = ((2*COORD_BITS+7)/8)*8;

   // walk state
   logic [COORD_BITS-1:0]        cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]        cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]        target_x_ff, target_x_in;
   logic [COORD_BITS-1:0]        target_y_ff, target_y_in;
   logic [COORD_BITS-1:0]        delta_x_ff, delta_x_in;
   logic [COORD_BITS-1:0]        delta_y_ff, delta_y_in;
   logic signed [COORD_BITS+1:0] error_ff, error_in;
   logic                         step_neg_x_ff, step_neg_x_in;
   logic                         step_neg_y_ff, step_neg_y_in;
   logic                         active_ff, active_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]        pixel_x_ff, pixel_x_in;
   logic [COORD_BITS-1:0]        pixel_y_ff, pixel_y_in;
   logic                         last_ff, last_in;

   logic                         req_fire;
   logic                         is_step;
   logic [COORD_BITS-1:0]        x_start, y_start, x_end, y_end;
   logic                         neg_x, neg_y;
   logic [COORD_BITS-1:0]        abs_dx, abs_dy;
   logic [COORD_BITS-1:0]        next_x, next_y;
   logic signed [COORD_BITS+1:0] next_error;
   lps_step_flags_type           step_flags;

   // unpack the request item
   assign x_start = req_tdata[COORD_BITS-1:0];
   assign y_start = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign x_end   = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign y_end   = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign is_step = (req_tuser == REQ_STEP);

   // take an item whenever the result register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // load set-up: step signs and absolute deltas
   assign neg_x  = !(x_start < x_end);
   assign neg_y  = !(y_start < y_end);
   assign abs_dx = neg_x ? (x_start - x_end) : (x_end - x_start);
   assign abs_dy = neg_y ? (y_start - y_end) : (y_end - y_start);

   // one walk step from the current state
   lps_step_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .cur_x      (cur_x_ff),
      .cur_y      (cur_y_ff),
      .target_x   (target_x_ff),
      .target_y   (target_y_ff),
      .delta_x    (delta_x_ff),
      .delta_y    (delta_y_ff),
      .error_term (error_ff),
      .step_neg_x (step_neg_x_ff),
      .step_neg_y (step_neg_y_ff),
      .next_x     (next_x),
      .next_y     (next_y),
      .next_error (next_error),
      .flags      (step_flags)
   );

   // next state of the walk and the result register
   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      target_x_in   = target_x_ff;
      target_y_in   = target_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      error_in      = error_ff;
      step_neg_x_in = step_neg_x_ff;
      step_neg_y_in = step_neg_y_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      pixel_x_in    = pixel_x_ff;
      pixel_y_in    = pixel_y_ff;
      last_in       = last_ff;
      if (req_fire) begin
         if (!is_step) begin
            cur_x_in      = x_start;
            cur_y_in      = y_start;
            target_x_in   = x_end;
            target_y_in   = y_end;
            delta_x_in    = abs_dx;
            delta_y_in    = abs_dy;
            error_in      = $signed({2'b00, abs_dx}) - $signed({2'b00, abs_dy});
            step_neg_x_in = neg_x;
            step_neg_y_in = neg_y;
            active_in     = (x_start != x_end) || (y_start != y_end);
         end else if (active_ff) begin
            rsp_valid_in = 1'b1;
            pixel_x_in   = cur_x_ff;
            pixel_y_in   = cur_y_ff;
            last_in      = step_flags.at_end;
            cur_x_in     = next_x;
            cur_y_in     = next_y;
            error_in     = next_error;
            active_in    = !step_flags.at_end;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      target_x_ff   <= target_x_in;
      target_y_ff   <= target_y_in;
      delta_x_ff    <= delta_x_in;
      delta_y_ff    <= delta_y_in;
      error_ff      <= error_in;
      step_neg_x_ff <= step_neg_x_in;
      step_neg_y_ff <= step_neg_y_in;
      pixel_x_ff    <= pixel_x_in;
      pixel_y_ff    <= pixel_y_in;
      last_ff       <= last_in;
   end

   // result outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({pixel_y_ff, pixel_x_ff});
   assign rsp_tlast  = last_ff;

   // checks
   `LPS_ASSERT_NEXT(a_step_gives_item, req_fire && is_step && active_ff, rsp_valid_ff)
   `LPS_ASSERT_NEXT(a_last_ends_line, req_fire && is_step && active_ff && step_flags.at_end, !active_ff)
   `LPS_ASSERT_NEXT(a_empty_load_idle, req_fire && !is_step && x_start == x_end && y_start == y_end, !active_ff)
   `LPS_ASSERT_NEXT(a_idle_step_no_item, req_fire && is_step && !active_ff && rsp_tready, !rsp_valid_ff)

endmodule
